### src/sld_pkg.sv
// ---------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync word, length prefixed deframer.
// ---------------------------------------------------------------------------
package sld_pkg;

   localparam int BYTE_W      = 8;
   localparam int SEQ_W       = 32;
   localparam int LEN_W       = 32;
   localparam int HDR_IDX_W   = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   typedef logic [BYTE_W-1:0]      byte_type;
   typedef logic [SEQ_W-1:0]       seq_type;
   typedef logic [LEN_W-1:0]       len_type;
   typedef logic [HDR_IDX_W-1:0]   hdr_idx_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // configuration register indexes
   localparam csr_index_type CSR_SYNC_FIRST  = 2'd0;
   localparam csr_index_type CSR_SYNC_SECOND = 2'd1;
   localparam csr_index_type CSR_SYNC_THIRD  = 2'd2;

   // header layout: type, 4 sequence bytes, 4 length bytes
   localparam hdr_idx_type HDR_IDX_TYPE    = 4'd0;
   localparam hdr_idx_type HDR_IDX_SEQ_END = 4'd4;
   localparam hdr_idx_type HDR_IDX_LAST    = 4'd8;

   // result kinds
   localparam logic ITEM_HEADER = 1'b0;
   localparam logic ITEM_BODY   = 1'b1;

   typedef enum logic [2:0] {
      PHASE_HUNT   = 3'b001,
      PHASE_HEADER = 3'b010,
      PHASE_BODY   = 3'b100
   } phase_type;

   typedef enum logic [1:0] {
      SYNC_NONE = 2'd0,
      SYNC_ONE  = 2'd1,
      SYNC_TWO  = 2'd2
   } sync_prog_type;

endpackage

### src/sld_req_if.sv
// ---------------------------------------------------------------------------
// sld_req_if
// Byte stream channel into the deframer: valid, ready and one received byte.
// ---------------------------------------------------------------------------
interface sld_req_if;
   import sld_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

### src/sld_rsp_if.sv
// ---------------------------------------------------------------------------
// sld_rsp_if
// Result channel out of the deframer: header results and body bytes.
// ---------------------------------------------------------------------------
interface sld_rsp_if;
   import sld_pkg::*;

   logic     valid;
   logic     ready;
   logic     item_kind;
   byte_type frame_type;
   seq_type  sequence_number;
   len_type  body_length;
   byte_type body_byte;
   logic     frame_last;

   modport source (
      output valid, output item_kind, output frame_type, output sequence_number,
      output body_length, output body_byte, output frame_last, input ready
   );
   modport sink (
      input valid, input item_kind, input frame_type, input sequence_number,
      input body_length, input body_byte, input frame_last, output ready
   );

endinterface

### src/sync_length_deframer_core.sv
// ---------------------------------------------------------------------------
// sync_length_deframer_core
// Hunts for a three byte sync marker, captures a nine byte header and passes
// the frame body through one byte at a time.
// ---------------------------------------------------------------------------
// One byte is taken on every clock cycle while the result register is empty
// or being drained in the same cycle; each byte is parsed in the cycle it is
// taken and any result appears on rsp_chan on the next cycle. After the sync
// bytes come one type byte, a big-endian sequence number and a big-endian
// body length; the header result follows the last length byte and carries
// frame_last when the length is zero. Every body byte is a result of its own
// that repeats the header fields, the final one marked with frame_last. A
// byte that breaks the sync marker restarts the hunt and is not retried as a
// first sync byte. The sync registers are written through csr_* and should
// change only while the block is idle.
// ---------------------------------------------------------------------------
module sync_length_deframer_core (
   input  logic                  clock,
   input  logic                  reset,
   sld_req_if.sink               req_chan,
   sld_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  sld_pkg::csr_index_type csr_index,
   input  sld_pkg::csr_data_type  csr_wdata
);
   import sld_pkg::*;

   byte_type      sync_first_ff, sync_second_ff, sync_third_ff;
   phase_type     phase_ff, phase_in;
   sync_prog_type sync_prog_ff, sync_prog_in;
   hdr_idx_type   hdr_idx_ff, hdr_idx_in;
   byte_type      type_ff, type_in;
   seq_type       seq_ff, seq_in;
   len_type       len_ff, len_in;
   len_type       remain_ff, remain_in;

   logic          rsp_valid_ff;
   logic          rsp_kind_ff;
   byte_type      rsp_type_ff;
   seq_type       rsp_seq_ff;
   len_type       rsp_len_ff;
   byte_type      rsp_byte_ff;
   logic          rsp_last_ff;

   logic          accept;
   logic          emit;
   logic          emit_kind;
   logic          emit_last;
   byte_type      emit_byte;
   byte_type      rx;
   len_type       remain_dec;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign rx             = req_chan.rx_byte;
   assign remain_dec     = remain_ff - len_type'(1);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= '0;
         sync_second_ff <= '0;
         sync_third_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            CSR_SYNC_SECOND: sync_second_ff <= csr_wdata;
            CSR_SYNC_THIRD:  sync_third_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // parser next state
   always_comb begin
      phase_in     = phase_ff;
      sync_prog_in = sync_prog_ff;
      hdr_idx_in   = hdr_idx_ff;
      type_in      = type_ff;
      seq_in       = seq_ff;
      len_in       = len_ff;
      remain_in    = remain_ff;
      emit         = 1'b0;
      emit_kind    = ITEM_HEADER;
      emit_last    = 1'b0;
      emit_byte    = '0;

      unique case (phase_ff)
         PHASE_HEADER: begin
            if (hdr_idx_ff == HDR_IDX_TYPE) begin
               type_in = rx;
            end else if (hdr_idx_ff <= HDR_IDX_SEQ_END) begin
               seq_in = {seq_ff[SEQ_W-BYTE_W-1:0], rx};
            end else begin
               len_in = {len_ff[LEN_W-BYTE_W-1:0], rx};
            end
            if (hdr_idx_ff >= HDR_IDX_LAST) begin
               hdr_idx_in = '0;
               emit       = 1'b1;
               emit_kind  = ITEM_HEADER;
               remain_in  = len_in;
               if (len_in == '0) begin
                  phase_in  = PHASE_HUNT;
                  emit_last = 1'b1;
               end else begin
                  phase_in  = PHASE_BODY;
               end
            end else begin
               hdr_idx_in = hdr_idx_ff + hdr_idx_type'(1);
            end
         end
         PHASE_BODY: begin
            remain_in = remain_dec;
            emit      = 1'b1;
            emit_kind = ITEM_BODY;
            emit_byte = rx;
            emit_last = (remain_dec == '0);
            if (remain_dec == '0) begin
               phase_in = PHASE_HUNT;
            end
         end
         default: begin
            // hunting, also any code that cannot be reached
            phase_in = PHASE_HUNT;
            priority if (sync_prog_ff == SYNC_NONE && rx == sync_first_ff) begin
               sync_prog_in = SYNC_ONE;
            end else if (sync_prog_ff == SYNC_ONE && rx == sync_second_ff) begin
               sync_prog_in = SYNC_TWO;
            end else if (sync_prog_ff == SYNC_TWO && rx == sync_third_ff) begin
               sync_prog_in = SYNC_NONE;
               phase_in     = PHASE_HEADER;
               hdr_idx_in   = '0;
               type_in      = '0;
               seq_in       = '0;
               len_in       = '0;
               remain_in    = '0;
            end else begin
               sync_prog_in = SYNC_NONE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HUNT;
         sync_prog_ff <= SYNC_NONE;
         hdr_idx_ff   <= '0;
         type_ff      <= '0;
         seq_ff       <= '0;
         len_ff       <= '0;
         remain_ff    <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         sync_prog_ff <= sync_prog_in;
         hdr_idx_ff   <= hdr_idx_in;
         type_ff      <= type_in;
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         remain_ff    <= remain_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_type_ff <= type_in;
         rsp_seq_ff  <= seq_in;
         rsp_len_ff  <= len_in;
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.item_kind       = rsp_kind_ff;
   assign rsp_chan.frame_type      = rsp_type_ff;
   assign rsp_chan.sequence_number = rsp_seq_ff;
   assign rsp_chan.body_length     = rsp_len_ff;
   assign rsp_chan.body_byte       = rsp_byte_ff;
   assign rsp_chan.frame_last      = rsp_last_ff;

   // header counter never runs past the last header byte
   a_hdr_idx_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_HEADER |-> hdr_idx_ff <= HDR_IDX_LAST)
      else $error("header index out of range");

   // in the body there is always at least one byte left
   a_body_remain: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_BODY |-> remain_ff != '0)
      else $error("body phase with nothing remaining");

   // every body byte transfer produces a result
   a_body_emits: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PHASE_BODY |=> rsp_valid_ff && rsp_kind_ff == ITEM_BODY)
      else $error("body byte lost");

   // hunting bytes never produce a result
   a_hunt_silent: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PHASE_HUNT && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result produced while hunting");

   // a result marked last (final body byte or header of an empty frame) returns the parser to the hunt
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      accept && emit && emit_last |=> phase_ff == PHASE_HUNT)
      else $error("frame end did not restart hunt");

endmodule
